// ===== rtl/pf_pkg.sv =====
`default_nettype none

package pf_pkg;

  // Letter and key square geometry.
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned SQ_DIM    = 5;
  localparam int unsigned ROW_W     = SQ_DIM * LETTER_W;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Depth of the pair queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Letter codes with a fixed role in the cipher.
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [SQ_DIM-1:0] square_t;

  // Key square after reset, row 0 in the lowest slot.
  localparam square_t SQUARE_RESET = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  // One digraph handed from the front part to the back part.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
  } pair_t;

  // Output side of the back part.
  typedef enum logic [1:0] {
    BK_EMPTY,
    BK_FIRST,
    BK_SECOND
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/pf_front.sv =====
`default_nettype none

module pf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pf_pkg::letter_t plain_letter,
  input  wire logic            message_end,
  output logic                 push,
  output pf_pkg::pair_t        push_pair,
  input  wire logic            q_full
);

  logic            held_valid;
  logic            held_valid_next;
  pf_pkg::letter_t held_letter;
  pf_pkg::letter_t held_letter_next;
  logic            pend_valid;
  logic            pend_valid_next;
  pf_pkg::pair_t   pend_pair;
  pf_pkg::pair_t   pend_pair_next;
  logic            accept;

  // A new letter is taken only when no second pair is waiting and the queue has room.
  assign in_ready = !pend_valid && !q_full;
  assign accept   = in_valid && in_ready;

  // Pair letters into digraphs, splitting doubled letters with x and padding a lone final letter with x.
  always_comb begin
    held_valid_next  = held_valid;
    held_letter_next = held_letter;
    pend_valid_next  = pend_valid;
    pend_pair_next   = pend_pair;
    push             = 1'b0;
    push_pair        = pend_pair;

    if (pend_valid) begin
      // The second pair of a doubled final letter goes out on its own cycle.
      if (!q_full) begin
        push            = 1'b1;
        pend_valid_next = 1'b0;
      end
    end else if (accept) begin
      if (!held_valid) begin
        if (message_end) begin
          push      = 1'b1;
          push_pair = '{first: plain_letter, second: pf_pkg::LETTER_X, last: 1'b1};
        end else begin
          held_valid_next  = 1'b1;
          held_letter_next = plain_letter;
        end
      end else if (held_letter != plain_letter) begin
        push             = 1'b1;
        push_pair        = '{first: held_letter, second: plain_letter, last: 1'b1};
        held_valid_next  = 1'b0;
        held_letter_next = '0;
      end else if (message_end) begin
        push             = 1'b1;
        push_pair        = '{first: held_letter, second: pf_pkg::LETTER_X, last: 1'b0};
        pend_valid_next  = 1'b1;
        pend_pair_next   = '{first: plain_letter, second: pf_pkg::LETTER_X, last: 1'b1};
        held_valid_next  = 1'b0;
        held_letter_next = '0;
      end else begin
        push             = 1'b1;
        push_pair        = '{first: held_letter, second: pf_pkg::LETTER_X, last: 1'b1};
        held_letter_next = plain_letter;
      end
    end
  end

  // Pairing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_letter <= '0;
      pend_valid  <= 1'b0;
    end else begin
      held_valid  <= held_valid_next;
      held_letter <= held_letter_next;
      pend_valid  <= pend_valid_next;
    end
  end

  // The waiting pair needs no reset.
  always_ff @(posedge clk) begin
    pend_pair <= pend_pair_next;
  end

endmodule

`default_nettype wire

// ===== rtl/pf_queue.sv =====
`default_nettype none

module pf_queue #(
  parameter int unsigned DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pf_pkg::pair_t push_pair,
  output logic               full,
  input  wire logic          pop,
  output pf_pkg::pair_t      head,
  output logic               head_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pf_pkg::pair_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Pair storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_pair;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pf_back.sv =====
`default_nettype none

module pf_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pf_pkg::pair_t                   head,
  input  wire logic                            head_valid,
  output logic                                 pop,
  input  wire logic                            cfg_valid,
  input  wire logic [pf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire pf_pkg::row_t                    cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pf_pkg::letter_t                      cipher_letter,
  output logic                                 run_last
);

  typedef logic [pf_pkg::POS_W-1:0] pos_idx_t;

  typedef struct packed {
    pos_idx_t row;
    pos_idx_t col;
  } pos_t;

  pf_pkg::square_t     square;
  pf_pkg::back_state_t state;
  pf_pkg::back_state_t state_next;
  pf_pkg::letter_t     res_a;
  pf_pkg::letter_t     res_b;
  logic                res_last;
  pos_t                pos_a;
  pos_t                pos_b;
  pf_pkg::letter_t     enc_a;
  pf_pkg::letter_t     enc_b;

  // Letter stored at one cell of the square.
  function automatic pf_pkg::letter_t cell_at(pf_pkg::square_t sq, pos_idx_t r, pos_idx_t c);
    return sq[r][c * pf_pkg::LETTER_W +: pf_pkg::LETTER_W];
  endfunction

  // Step to the next row or column, wrapping at the edge of the square.
  function automatic pos_idx_t wrap_inc(pos_idx_t v);
    return (v == pf_pkg::POS_W'(pf_pkg::SQ_DIM - 1)) ? '0 : v + pf_pkg::POS_W'(1);
  endfunction

  // Find a letter in the square; the first match in row-major order wins and
  // a letter that is absent is placed at row 0, column 0. j is looked up as i.
  function automatic pos_t locate(pf_pkg::square_t sq, pf_pkg::letter_t letter);
    pf_pkg::letter_t key;
    pos_t            pos;
    key = (letter == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : letter;
    pos = '0;
    for (int r = pf_pkg::SQ_DIM - 1; r >= 0; r--) begin
      for (int c = pf_pkg::SQ_DIM - 1; c >= 0; c--) begin
        if (sq[r][c * pf_pkg::LETTER_W +: pf_pkg::LETTER_W] == key) begin
          pos.row = pf_pkg::POS_W'(r);
          pos.col = pf_pkg::POS_W'(c);
        end
      end
    end
    return pos;
  endfunction

  // Key square registers, written through the configuration channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      square <= pf_pkg::SQUARE_RESET;
    end else if (cfg_valid && (cfg_index < pf_pkg::CFG_IDX_W'(pf_pkg::SQ_DIM))) begin
      square[cfg_index] <= cfg_data;
    end
  end

  // Encrypt the pair at the head of the queue.
  always_comb begin
    pos_a = locate(square, head.first);
    pos_b = locate(square, head.second);
    if (pos_a.row == pos_b.row) begin
      enc_a = cell_at(square, pos_a.row, wrap_inc(pos_a.col));
      enc_b = cell_at(square, pos_b.row, wrap_inc(pos_b.col));
    end else if (pos_a.col == pos_b.col) begin
      enc_a = cell_at(square, wrap_inc(pos_a.row), pos_a.col);
      enc_b = cell_at(square, wrap_inc(pos_b.row), pos_b.col);
    end else begin
      enc_a = cell_at(square, pos_a.row, pos_b.col);
      enc_b = cell_at(square, pos_b.row, pos_a.col);
    end
  end

  // Output sequencing: the first letter, then the second, then the next pair.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      pf_pkg::BK_EMPTY: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = pf_pkg::BK_FIRST;
        end
      end
      pf_pkg::BK_FIRST: begin
        if (out_ready) begin
          state_next = pf_pkg::BK_SECOND;
        end
      end
      pf_pkg::BK_SECOND: begin
        if (out_ready) begin
          if (head_valid) begin
            pop        = 1'b1;
            state_next = pf_pkg::BK_FIRST;
          end else begin
            state_next = pf_pkg::BK_EMPTY;
          end
        end
      end
      default: begin
        state_next = pf_pkg::BK_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pf_pkg::BK_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Result registers, loaded as a pair leaves the queue.
  always_ff @(posedge clk) begin
    if (pop) begin
      res_a    <= enc_a;
      res_b    <= enc_b;
      res_last <= head.last;
    end
  end

  assign out_valid     = (state != pf_pkg::BK_EMPTY);
  assign cipher_letter = (state == pf_pkg::BK_SECOND) ? res_b : res_a;
  assign run_last      = (state == pf_pkg::BK_SECOND) && res_last;

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_encryptor.sv =====
// Playfair encryptor over a 5x5 key square held in five row registers.
// Input channel (in_valid/in_ready): one plaintext letter per request, codes
// a=0 through z=25, with message_end on the final letter of a message.
// Output channel (out_valid/out_ready): ciphertext letters, two per digraph;
// run_last marks the last letter caused by one input request.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0 to 4 selects a
// square row and cfg_data carries five letter codes, column 0 in the low bits.
// Rows may be rewritten only while the block is idle; cfg_ready is always high.
// A pair passes through the queue and into the result registers before its
// first letter appears; the second letter follows once the first is taken.
// Throughput: one request per cycle is taken while no second pair waits and
// the queue has room, and one letter per cycle leaves while out_ready is high;
// the output register pair in the back part sets the letter rate. A doubled
// final letter yields two digraphs, and the input is held until both are queued.
// Reset loads the default key square and empties the pairing state and queue.
// When the receiver stalls, results wait in the output register and the pair
// queue, and the input keeps being taken until the queue fills.
`default_nettype none

module playfair_digraph_encryptor #(
  parameter int unsigned QUEUE_DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [4:0]                   plain_letter,
  input  wire logic                         message_end,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [4:0]                        cipher_letter,
  output logic                              run_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [24:0]                  cfg_data
);

  logic          push;
  pf_pkg::pair_t push_pair;
  logic          q_full;
  logic          pop;
  pf_pkg::pair_t head;
  logic          head_valid;

  assign cfg_ready = 1'b1;

  // Pairing of letters into digraphs.
  pf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .plain_letter (plain_letter),
    .message_end  (message_end),
    .push         (push),
    .push_pair    (push_pair),
    .q_full       (q_full)
  );

  // Digraphs waiting for encryption.
  pf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pair  (push_pair),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Square lookup and ciphertext output.
  pf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cipher_letter (cipher_letter),
    .run_last      (run_last)
  );

endmodule

`default_nettype wire
